[sv/key_group_debouncer_defines.svh]
// assertion macros for the key group debouncer
// used by key_group_debouncer.sv; expects i_clk and i_rst_n in scope
`ifndef KEY_GROUP_DEBOUNCER_DEFINES_SVH
`define KEY_GROUP_DEBOUNCER_DEFINES_SVH
`ifndef SYNTHESIS
`define KGD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kgd check failed");
`define KGD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kgd check failed");
`else
`define KGD_ASSERT_SAME(lbl, ante, cons)
`define KGD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/kgd_pkg.sv]
// types and constants shared by the key group debouncer
// no dependencies
`default_nettype none

package kgd_pkg;

    localparam int POS_W    = 4;
    localparam int KEY_W    = 3;
    localparam int COUNT_W  = 8;

    localparam logic [KEY_W-1:0]   ALL_RELEASED = 3'b111;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'hFF;
    localparam logic [COUNT_W-1:0] THRESH_RESET = 8'd16;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [KEY_W-1:0] sample_bits;
    } t_key_sample;

    typedef struct packed {
        logic             change_valid;
        logic [KEY_W-1:0] changed_mask;
        logic [KEY_W-1:0] accepted_bits;
    } t_key_report;

    typedef struct packed {
        logic        fire;
        t_key_sample sample;
    } t_step_ctrl;

endpackage

`default_nettype wire

[sv/kgd_chan_if.sv]
// valid/ready channel carrying one payload of type T
// payload types come from kgd_pkg
`default_nettype none

interface kgd_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/kgd_core.sv]
// per-position accepted state and bounce counters with the update logic
// depends on kgd_pkg
`default_nettype none

module kgd_core #(
    parameter int DEPTH = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  kgd_pkg::t_step_ctrl              i_ctrl,
    input  wire  [kgd_pkg::COUNT_W-1:0]      i_threshold,
    output kgd_pkg::t_key_report             o_report
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [kgd_pkg::KEY_W-1:0]   r_state [DEPTH];
    logic [kgd_pkg::COUNT_W-1:0] r_count [DEPTH];

    logic                        in_range;
    logic [IDX_W-1:0]            idx;
    logic [kgd_pkg::KEY_W-1:0]   sample;
    logic [kgd_pkg::KEY_W-1:0]   old_state;
    logic [kgd_pkg::COUNT_W-1:0] old_count;
    logic                        differ;
    logic                        take;
    logic [kgd_pkg::COUNT_W-1:0] n_count;

    assign in_range = (32'(i_ctrl.sample.position) < DEPTH);
    assign idx      = IDX_W'(i_ctrl.sample.position);
    assign sample   = i_ctrl.sample.sample_bits;

    always_comb begin
        old_state = kgd_pkg::ALL_RELEASED;
        old_count = '0;
        if (in_range) begin
            old_state = r_state[idx];
            old_count = r_count[idx];
        end
    end

    assign differ = (sample != old_state);
    assign take   = in_range && differ && (old_count > i_threshold);

    // 0 on accept, else up if differing (saturating), down if same
    always_comb begin
        n_count = old_count;
        if (take) begin
            n_count = '0;
        end else if (differ) begin
            if (old_count != kgd_pkg::COUNT_MAX) begin
                n_count = old_count + 1'b1;
            end
        end else if (old_count != '0) begin
            n_count = old_count - 1'b1;
        end
    end

    always_comb begin
        o_report.change_valid  = take;
        o_report.changed_mask  = take ? (sample ^ old_state) : '0;
        o_report.accepted_bits = take ? sample : old_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_state[i] <= kgd_pkg::ALL_RELEASED;
                r_count[i] <= '0;
            end
        end else if (i_ctrl.fire && in_range) begin
            r_count[idx] <= n_count;
            if (take) begin
                r_state[idx] <= sample;
            end
        end
    end

endmodule

`default_nettype wire

[sv/key_group_debouncer.sv]
// top level of the key group debouncer: handshake, input and result registers
// depends on kgd_pkg, kgd_chan_if, kgd_core and key_group_debouncer_defines.svh
`default_nettype none
`include "key_group_debouncer_defines.svh"

// Counter-based debouncer for scanned groups of three keys. Each sample transfer
// carries a position and three raw key bits (1 = released); each transfer out
// reports whether a new state was accepted for that position, which bits changed
// and the accepted state after the sample. One sample is taken every clock cycle
// while the report channel is not stalled; its report passes through the input
// register, then the result register, and the position's state and counter entry
// are updated as the sample moves from one to the other. Positions at or above
// POSITIONS report no change and all keys released. The threshold register (reset
// 16) is written on the configuration channel, which is always ready, and should
// only be written while no samples are in flight.
module key_group_debouncer #(
    parameter int POSITIONS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    kgd_chan_if.sink    i_sample,
    kgd_chan_if.source  o_report,
    kgd_chan_if.sink    i_cfg
);

    // only 16 positions can be addressed by the 4-bit position field
    localparam int DEPTH = (POSITIONS < (1 << kgd_pkg::POS_W)) ? POSITIONS
                                                               : (1 << kgd_pkg::POS_W);

    logic [kgd_pkg::COUNT_W-1:0] r_threshold;
    logic                        r_in_valid;
    kgd_pkg::t_key_sample        r_in_payload;
    logic                        r_out_valid;
    kgd_pkg::t_key_report        r_out_payload;

    logic                        step_fire;
    logic                        in_fire;
    kgd_pkg::t_step_ctrl         ctrl;
    kgd_pkg::t_key_report        report;

    assign step_fire = r_in_valid && (!r_out_valid || o_report.ready);
    assign in_fire   = i_sample.valid && i_sample.ready;

    assign i_sample.ready = !r_in_valid || step_fire;
    assign i_cfg.ready    = 1'b1;
    assign o_report.valid   = r_out_valid;
    assign o_report.payload = r_out_payload;

    assign ctrl.fire   = step_fire;
    assign ctrl.sample = r_in_payload;

    kgd_core #(
        .DEPTH(DEPTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_threshold(r_threshold),
        .o_report   (report)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= kgd_pkg::THRESH_RESET;
        end else if (i_cfg.valid) begin
            r_threshold <= i_cfg.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (step_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_payload <= i_sample.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_report.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out_payload <= report;
        end
    end

    `KGD_ASSERT_SAME(a_change_has_mask, r_out_valid && r_out_payload.change_valid, r_out_payload.changed_mask != '0)
    `KGD_ASSERT_SAME(a_no_change_no_mask, r_out_valid && !r_out_payload.change_valid, r_out_payload.changed_mask == '0)
    `KGD_ASSERT_SAME(a_stall_means_busy, !i_sample.ready, r_in_valid && r_out_valid)
    `KGD_ASSERT_NEXT(a_report_kept, r_out_valid && !o_report.ready, r_out_valid)

endmodule

`default_nettype wire
